// ----- design/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/cs20_pkg.sv -----
// Shared types, constants and block-function helpers for the ChaCha20 stream XOR unit.
package cs20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUND_STEPS   = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W        = $clog2(ROUND_STEPS);
    localparam int ADDR_W        = 6;
    localparam int DATA_W        = 64;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] block_t;

    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646e;
    localparam word_t SIGMA2 = 32'h79622d32;
    localparam word_t SIGMA3 = 32'h6b206574;

    typedef enum logic [2:0] {
        REG_KEY0     = 3'd0,
        REG_KEY1     = 3'd1,
        REG_KEY2     = 3'd2,
        REG_KEY3     = 3'd3,
        REG_NONCE_LO = 3'd4,
        REG_NONCE_HI = 3'd5,
        REG_INIT_CTR = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_CTR = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [63:0] key2;
        logic [63:0] key3;
        logic [63:0] nonce_lo;
        word_t       nonce_hi;
        word_t       init_ctr;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] err;
        logic [5:0] pos;
        logic       new_blk;
        word_t      ctr;
    } item_t;

    typedef struct packed {
        logic [7:0] val;
        logic       last;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    function automatic block_t init_block(input cfg_t c, input word_t ctr);
        block_t b;
        b[0]  = SIGMA0;
        b[1]  = SIGMA1;
        b[2]  = SIGMA2;
        b[3]  = SIGMA3;
        b[4]  = c.key0[31:0];
        b[5]  = c.key0[63:32];
        b[6]  = c.key1[31:0];
        b[7]  = c.key1[63:32];
        b[8]  = c.key2[31:0];
        b[9]  = c.key2[63:32];
        b[10] = c.key3[31:0];
        b[11] = c.key3[63:32];
        b[12] = ctr;
        b[13] = c.nonce_lo[31:0];
        b[14] = c.nonce_lo[63:32];
        b[15] = c.nonce_hi;
        return b;
    endfunction

    // Half quarter-round: rotations 16/12 in the first half, 8/7 in the second.
    function automatic quad_t half_qr(input quad_t q, input logic second);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t x;
        word_t y;
        quad_t r;
        a = q.a + q.b;
        x = q.d ^ a;
        d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
        c = q.c + d;
        y = q.b ^ c;
        b = second ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        return r;
    endfunction

endpackage

// ----- design/chacha20_stream_xor_unit.sv -----
// Top level of the ChaCha20 stream XOR unit.
// Flow: a pushed byte passes through the front queue and then the result queue; a byte that
// opens a block first waits for the block function (load, 40 half-round steps, final add).
// Throughput: one byte per cycle within a block while the result side is not stalled.
// Reset: counter, byte position and error code clear; initial_counter resets to 1.
module chacha20_stream_xor_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [cs20_pkg::ADDR_W-1:0] paddr,
    input  logic [cs20_pkg::DATA_W-1:0] pwdata,
    output logic [cs20_pkg::DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            data_byte,
    input  logic                  first_byte,
    input  logic                  last_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            out_byte,
    output logic                  out_last,
    output logic [1:0]            status
);
    import cs20_pkg::*;

    cfg_t  cfg;
    item_t q_head;
    logic  q_empty;
    logic  q_pop;
    res_t  res;

    cs20_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cs20_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .init_ctr   (cfg.init_ctr),
        .q_pop      (q_pop),
        .q_empty    (q_empty),
        .q_head     (q_head)
    );

    cs20_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_empty (empty),
        .res_pop   (pop),
        .res       (res)
    );

    assign out_byte = res.val;
    assign out_last = res.last;
    assign status   = res.status;

endmodule

// ----- design/cs20_cfg.sv -----
// APB-style configuration register file.
module cs20_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [cs20_pkg::ADDR_W-1:0] paddr,
    input  logic [cs20_pkg::DATA_W-1:0] pwdata,
    output logic [cs20_pkg::DATA_W-1:0] prdata,
    output logic                  pready,
    output cs20_pkg::cfg_t        cfg
);
    import cs20_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key0     <= '0;
            cfg_reg.key1     <= '0;
            cfg_reg.key2     <= '0;
            cfg_reg.key3     <= '0;
            cfg_reg.nonce_lo <= '0;
            cfg_reg.nonce_hi <= '0;
            cfg_reg.init_ctr <= 32'd1;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_KEY0:     cfg_reg.key0     <= pwdata;
                REG_KEY1:     cfg_reg.key1     <= pwdata;
                REG_KEY2:     cfg_reg.key2     <= pwdata;
                REG_KEY3:     cfg_reg.key3     <= pwdata;
                REG_NONCE_LO: cfg_reg.nonce_lo <= pwdata;
                REG_NONCE_HI: cfg_reg.nonce_hi <= pwdata[31:0];
                REG_INIT_CTR: cfg_reg.init_ctr <= pwdata[31:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_KEY0:     prdata = cfg_reg.key0;
            REG_KEY1:     prdata = cfg_reg.key1;
            REG_KEY2:     prdata = cfg_reg.key2;
            REG_KEY3:     prdata = cfg_reg.key3;
            REG_NONCE_LO: prdata = cfg_reg.nonce_lo;
            REG_NONCE_HI: prdata = {32'd0, cfg_reg.nonce_hi};
            REG_INIT_CTR: prdata = {32'd0, cfg_reg.init_ctr};
            default:      prdata = '0;
        endcase
    end

endmodule

// ----- design/cs20_front.sv -----
// Front end: accepts bytes, tracks counter/position/error, queues classified items.
module cs20_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       data_byte,
    input  logic             first_byte,
    input  logic             last_byte,
    input  cs20_pkg::word_t  init_ctr,
    input  logic             q_pop,
    output logic             q_empty,
    output cs20_pkg::item_t  q_head
);
    import cs20_pkg::*;

    word_t      ctr_reg;
    word_t      ctr_next;
    logic [1:0] err_reg;
    logic [1:0] err_next;
    logic [5:0] pos_reg;
    logic [5:0] pos_eff;
    logic       new_blk;
    logic       accept;
    item_t      item;

    item_t      q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign accept  = push && !full;
    assign q_head  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        pos_eff  = first_byte ? 6'd0 : pos_reg;
        new_blk  = first_byte || (pos_reg == 6'd0);
        ctr_next = ctr_reg;
        err_next = err_reg;
        if (first_byte)
        begin
            ctr_next = init_ctr;
            err_next = (init_ctr == 32'd0) ? ST_ZERO_CTR : ST_OK;
        end
        else if (pos_reg == 6'd0)
        begin
            if (ctr_reg == 32'hffff_ffff)
            begin
                if (err_reg == ST_OK)
                begin
                    err_next = ST_OVERFLOW;
                end
            end
            else
            begin
                ctr_next = ctr_reg + 32'd1;
            end
        end
        item.data    = data_byte;
        item.last    = last_byte;
        item.err     = err_next;
        item.pos     = pos_eff;
        item.new_blk = new_blk;
        item.ctr     = ctr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg    <= '0;
            err_reg    <= ST_OK;
            pos_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                ctr_reg    <= ctr_next;
                err_reg    <= err_next;
                pos_reg    <= pos_eff + 6'd1;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, accept} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- design/cs20_core.sv -----
// Back end: block function (half quarter-round per cycle), keystream XOR, result queue.
module cs20_core (
    input  logic             clk,
    input  logic             rst_n,
    input  cs20_pkg::cfg_t   cfg,
    input  logic             q_empty,
    input  cs20_pkg::item_t  q_head,
    output logic             q_pop,
    output logic             res_empty,
    input  logic             res_pop,
    output cs20_pkg::res_t   res
);
    import cs20_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_FINAL
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              fresh_reg;

    block_t     rs_reg;
    block_t     rs_next;
    block_t     ks_reg;
    block_t     init;
    logic       start;
    logic       emit;
    logic       room;
    word_t      ks_word;
    logic [7:0] ks_byte;
    res_t       res_item;

    res_t       res_mem_reg [2];
    logic       res_wr_reg;
    logic       res_rd_reg;
    logic [1:0] res_cnt_reg;

    assign init      = init_block(cfg, q_head.ctr);
    assign room      = (res_cnt_reg != 2'd2);
    assign start     = (state_reg == S_IDLE) && !q_empty && q_head.new_blk && !fresh_reg;
    assign emit      = (state_reg == S_IDLE) && !q_empty && room
                       && (!q_head.new_blk || fresh_reg);
    assign q_pop     = emit;
    assign res_empty = (res_cnt_reg == 2'd0);
    assign res       = res_mem_reg[res_rd_reg];

    assign ks_word = ks_reg[q_head.pos[5:2]];
    assign ks_byte = ks_word[{q_head.pos[1:0], 3'b000} +: 8];

    always_comb
    begin
        res_item.val    = (q_head.err != ST_OK) ? 8'd0 : (q_head.data ^ ks_byte);
        res_item.last   = q_head.last;
        res_item.status = q_head.err;
    end

    // Four lanes; step bit 1 picks column or diagonal, bit 0 picks the half.
    always_comb
    begin
        logic [1:0] lb;
        logic [1:0] lc;
        logic [1:0] ld;
        quad_t      qi;
        quad_t      qo;
        rs_next = rs_reg;
        for (int j = 0; j < 4; j++)
        begin
            lb   = 2'(j) + {1'b0, step_reg[1]};
            lc   = 2'(j) + {step_reg[1], 1'b0};
            ld   = 2'(j) + {step_reg[1], step_reg[1]};
            qi.a = rs_reg[{2'b00, 2'(j)}];
            qi.b = rs_reg[{2'b01, lb}];
            qi.c = rs_reg[{2'b10, lc}];
            qi.d = rs_reg[{2'b11, ld}];
            qo   = half_qr(qi, step_reg[0]);
            rs_next[{2'b00, 2'(j)}] = qo.a;
            rs_next[{2'b01, lb}]    = qo.b;
            rs_next[{2'b10, lc}]    = qo.c;
            rs_next[{2'b11, ld}]    = qo.d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_ROUND;
                    end
                    else if (emit)
                    begin
                        fresh_reg <= 1'b0;
                    end
                end
                S_ROUND:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(ROUND_STEPS - 1))
                    begin
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    fresh_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rs_reg <= init;
        end
        else if (state_reg == S_ROUND)
        begin
            rs_reg <= rs_next;
        end
        if (state_reg == S_FINAL)
        begin
            for (int i = 0; i < 16; i++)
            begin
                ks_reg[i] <= rs_reg[i] + init[i];
            end
        end
        if (emit)
        begin
            res_mem_reg[res_wr_reg] <= res_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= 1'b0;
            res_rd_reg  <= 1'b0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (emit)
            begin
                res_wr_reg <= ~res_wr_reg;
            end
            if (res_pop && !res_empty)
            begin
                res_rd_reg <= ~res_rd_reg;
            end
            res_cnt_reg <= res_cnt_reg + {1'b0, emit} - {1'b0, res_pop && !res_empty};
        end
    end

endmodule

// ----- design/cs20_checker.sv -----
// Port-level checker for the ChaCha20 stream XOR unit, bound to the top level.
`include "assert_macros.svh"

module cs20_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pready,
    input logic                  empty,
    input logic                  pop,
    input logic [7:0]            out_byte,
    input logic                  out_last,
    input logic [1:0]            status
);
    import cs20_pkg::*;

    `CHK_ALWAYS(a_err_zero_byte, clk, rst_n, empty || status == ST_OK || out_byte == 8'd0, "error result carries nonzero byte")
    `CHK_NEXT(a_res_hold, clk, rst_n, !empty && !pop, !empty && $stable({out_byte, out_last, status}), "stalled result changed")
    `CHK_ALWAYS(a_pready_high, clk, rst_n, pready, "pready dropped")

endmodule

bind chacha20_stream_xor_unit cs20_checker u_checker (.*);

// ----- tb/tb_chacha20_stream_xor_unit.sv -----
// Self-checking testbench for the ChaCha20 stream XOR unit: keystream prediction and byte checks.
`timescale 1ns / 1ps

module tb_chacha20_stream_xor_unit;
    import cs20_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 140;
    localparam int NUM_PHASES   = 8;

    class cs20_keystream_checker;
        logic [63:0] key_part [4];
        logic [63:0] nonce_lo;
        word_t       nonce_hi;
        word_t       init_ctr;
        word_t       ks_words [16];
        word_t       work [16];
        word_t       blk_ctr;
        logic [5:0]  byte_pos;
        status_t     err_code;
        res_t        expected_bytes [$];
        int          failures;

        function new();
            for (int i = 0; i < 4; i++)
                key_part[i] = '0;
            nonce_lo = '0;
            nonce_hi = '0;
            init_ctr = 32'd1;
            blk_ctr  = '0;
            byte_pos = '0;
            err_code = ST_OK;
            failures = 0;
        endfunction

        function void write_cfg(reg_idx_t idx, logic [63:0] value);
            case (idx)
                REG_KEY0:     key_part[0] = value;
                REG_KEY1:     key_part[1] = value;
                REG_KEY2:     key_part[2] = value;
                REG_KEY3:     key_part[3] = value;
                REG_NONCE_LO: nonce_lo = value;
                REG_NONCE_HI: nonce_hi = value[31:0];
                REG_INIT_CTR: init_ctr = value[31:0];
                default: ;
            endcase
        endfunction

        function word_t rotl(word_t v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void mix_quad(int a, int b, int c, int d);
            work[a] = work[a] + work[b]; work[d] = rotl(work[d] ^ work[a], 16);
            work[c] = work[c] + work[d]; work[b] = rotl(work[b] ^ work[c], 12);
            work[a] = work[a] + work[b]; work[d] = rotl(work[d] ^ work[a], 8);
            work[c] = work[c] + work[d]; work[b] = rotl(work[b] ^ work[c], 7);
        endfunction

        function void gen_keystream_block();
            word_t start [16];
            start[0] = SIGMA0;
            start[1] = SIGMA1;
            start[2] = SIGMA2;
            start[3] = SIGMA3;
            for (int k = 0; k < 4; k++)
            begin
                start[4 + 2 * k] = key_part[k][31:0];
                start[5 + 2 * k] = key_part[k][63:32];
            end
            start[12] = blk_ctr;
            start[13] = nonce_lo[31:0];
            start[14] = nonce_lo[63:32];
            start[15] = nonce_hi;
            for (int i = 0; i < 16; i++)
                work[i] = start[i];
            for (int r = 0; r < DOUBLE_ROUNDS; r++)
            begin
                mix_quad(0, 4, 8, 12);
                mix_quad(1, 5, 9, 13);
                mix_quad(2, 6, 10, 14);
                mix_quad(3, 7, 11, 15);
                mix_quad(0, 5, 10, 15);
                mix_quad(1, 6, 11, 12);
                mix_quad(2, 7, 8, 13);
                mix_quad(3, 4, 9, 14);
            end
            for (int i = 0; i < 16; i++)
                ks_words[i] = work[i] + start[i];
        endfunction

        function void note_input(logic [7:0] d, logic is_first, logic is_last);
            res_t       r;
            logic [7:0] ks_byte;
            if (is_first)
            begin
                blk_ctr  = init_ctr;
                byte_pos = '0;
                err_code = (init_ctr == 32'd0) ? ST_ZERO_CTR : ST_OK;
            end
            else if (byte_pos == 6'd0)
            begin
                if (blk_ctr == 32'hffffffff)
                begin
                    if (err_code == ST_OK)
                        err_code = ST_OVERFLOW;
                end
                else
                    blk_ctr = blk_ctr + 32'd1;
            end
            if (byte_pos == 6'd0)
                gen_keystream_block();
            ks_byte  = 8'(ks_words[byte_pos[5:2]] >> (8 * byte_pos[1:0]));
            r.val    = (err_code != ST_OK) ? 8'h00 : (d ^ ks_byte);
            r.last   = is_last;
            r.status = err_code;
            expected_bytes.push_back(r);
            byte_pos = byte_pos + 6'd1;
        endfunction

        function void check_result(logic [7:0] v, logic l, logic [1:0] s);
            res_t e;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected result out_byte=%h out_last=%b status=%0d",
                         $time, v, l, s);
                failures++;
            end
            else
            begin
                e = expected_bytes.pop_front();
                if (v !== e.val)
                begin
                    $display("%0t: out_byte expected %h actual %h", $time, e.val, v);
                    failures++;
                end
                if (l !== e.last)
                begin
                    $display("%0t: out_last expected %b actual %b", $time, e.last, l);
                    failures++;
                end
                if (s !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, s);
                    failures++;
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              push = 1'b0;
    logic              full;
    logic [7:0]        data_byte = '0;
    logic              first_byte = 1'b0;
    logic              last_byte = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic [7:0]        out_byte;
    logic              out_last;
    logic [1:0]        status;

    cs20_keystream_checker checker_h = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit want_hold = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;

    chacha20_stream_xor_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .status     (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: check each transfer, random stalls, one long hold-off on request.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            checker_h.check_result(out_byte, out_last, status);
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end
        else if (want_hold)
        begin
            want_hold = 1'b0;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] d, input logic is_first, input logic is_last);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        data_byte  <= d;
        first_byte <= is_first;
        last_byte  <= is_last;
        @(posedge clk);
        while (full) @(posedge clk);
        checker_h.note_input(d, is_first, is_last);
    endtask

    task automatic wait_for_results();
        push <= 1'b0;
        @(posedge clk);
        while (checker_h.expected_bytes.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg_reg(input reg_idx_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        checker_h.write_cfg(idx, value);
        @(posedge clk);
    endtask

    function automatic logic [63:0] pick_wide();
        case ($urandom_range(5))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        logic [31:0] ctr_val;
        logic [63:0] wide;
        int          left;
        int          len;
        int          noise;
        logic        lst;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 78;

        // continuation after reset, byte extremes, last echo, byte after last
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'ha5, 1'b0, 1'b1);
        send_byte(8'h5a, 1'b0, 1'b0);
        wait_for_results();

        write_cfg_reg(REG_KEY0, '1);
        write_cfg_reg(REG_KEY1, '1);
        write_cfg_reg(REG_KEY2, '1);
        write_cfg_reg(REG_KEY3, '1);
        write_cfg_reg(REG_NONCE_LO, '1);
        write_cfg_reg(REG_NONCE_HI, 64'h0000_0000_ffff_ffff);
        write_cfg_reg(REG_INIT_CTR, 64'h0000_0000_ffff_ffff);
        send_byte(8'hff, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h3c, 1'b0, 1'b0);
        send_byte(8'hc3, 1'b0, 1'b1);
        wait_for_results();

        // zero initial counter: sticky status until the next message start
        write_cfg_reg(REG_INIT_CTR, 64'd0);
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'hff, 1'b0, 1'b1);
        send_byte(8'h34, 1'b0, 1'b0);
        wait_for_results();
        write_cfg_reg(REG_INIT_CTR, 64'd1);
        send_byte(8'h80, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        wait_for_results();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 78;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0, 4, 7: ctr_val = 32'hffffffff;
                2:       ctr_val = 32'd0;
                3:       ctr_val = 32'hfffffffe;
                5:       ctr_val = 32'd1;
                default: ctr_val = $urandom;
            endcase
            write_cfg_reg(REG_KEY0, pick_wide());
            write_cfg_reg(REG_KEY1, pick_wide());
            write_cfg_reg(REG_KEY2, pick_wide());
            write_cfg_reg(REG_KEY3, pick_wide());
            write_cfg_reg(REG_NONCE_LO, pick_wide());
            wide = pick_wide();
            write_cfg_reg(REG_NONCE_HI, {32'd0, wide[31:0]});
            write_cfg_reg(REG_INIT_CTR, {32'd0, ctr_val});
            if (ph == 6)
                want_hold = 1'b1;

            left = PHASE_ITEMS;
            while (left > 0)
            begin
                if ($urandom_range(2) == 0)
                    len = $urandom_range(65, 150);
                else
                    len = $urandom_range(1, 24);
                if (len > left)
                    len = left;
                noise = $urandom_range(9);
                for (int i = 0; i < len; i++)
                begin
                    lst = (i == len - 1);
                    if (noise == 1 && $urandom_range(7) == 0)
                        lst = ~lst;
                    send_byte(8'($urandom_range(255)), (i == 0) && (noise != 0), lst);
                end
                left = left - len;
            end
            wait_for_results();
        end

        repeat (60) @(posedge clk);
        if (checker_h.failures == 0 && checker_h.expected_bytes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
